[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when NO_ASSERTIONS is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[sv/lr_pkg.sv]
// ---------------------------------------------------------------------------
// lr_pkg
// shared constants and types for the line rasteriser
// ---------------------------------------------------------------------------
package lr_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;

  localparam int XW    = 9;   // column width
  localparam int YW    = 8;   // row width
  localparam int AW    = 16;  // byte address width
  localparam int CW    = 4;   // colour width
  localparam int ERR_W = 11;  // signed error term

  localparam logic [XW-1:0] X_MAX     = XW'(SCREEN_WIDTH - 1);
  localparam logic [YW-1:0] Y_MAX     = YW'(SCREEN_HEIGHT - 1);
  localparam logic [AW-1:0] ROW_BYTES = AW'(SCREEN_WIDTH / 2);

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [AW-1:0] addr;
    logic          upper;
    logic [CW-1:0] color;
    logic          last;
  } pixel_t;

endpackage

[sv/line_rasterizer_top.sv]
// ---------------------------------------------------------------------------
// line_rasterizer_top
// bresenham line engine emitting packed 4bpp framebuffer pixel addresses
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | command, start_x, start_y, end_x, end_y,
//          |                      | pen_color
//  out     | out_valid / out_ready| pixel_x, pixel_y, byte_address,
//          |                      | upper_nibble, pixel_color, last_pixel
//
//  one item per clock while in_ready is high; each pixel is registered into out_pix, or into the skid while out stalls
//  the error step and address are one combinational pass off the line state
//  a skid register holds one extra pixel, in_ready drops only when it is full
//  rst clears the line state to idle and empties both output registers
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module line_rasterizer_top
  import lr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          command,
  input  logic [XW-1:0] start_x,
  input  logic [YW-1:0] start_y,
  input  logic [XW-1:0] end_x,
  input  logic [YW-1:0] end_y,
  input  logic [CW-1:0] pen_color,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [XW-1:0] pixel_x,
  output logic [YW-1:0] pixel_y,
  output logic [AW-1:0] byte_address,
  output logic          upper_nibble,
  output logic [CW-1:0] pixel_color,
  output logic          last_pixel
);

  // line state
  logic [XW-1:0]    cur_x, cur_x_next;
  logic [YW-1:0]    cur_y, cur_y_next;
  logic [XW-1:0]    tgt_x, tgt_x_next;
  logic [YW-1:0]    tgt_y, tgt_y_next;
  logic [XW-1:0]    delta_x, delta_x_next;
  logic [XW-1:0]    neg_delta_y, neg_delta_y_next;
  logic             x_neg, x_neg_next;
  logic             y_neg, y_neg_next;
  logic [ERR_W-1:0] err, err_next;
  logic [CW-1:0]    color, color_next;
  logic             busy, busy_next;

  // output registers
  pixel_t out_pix, skid_pix, res;
  logic   skid_valid;

  logic in_fire, res_fire, last;

  logic [XW-1:0]    x0, x1, dx_abs;
  logic [YW-1:0]    y0, y1, dy_abs;
  logic [ERR_W:0]   e2;
  logic             adv_x, adv_y;
  logic [ERR_W-1:0] ndy_ext, dx_ext;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    x0 = (start_x > X_MAX) ? X_MAX : start_x;
    y0 = (start_y > Y_MAX) ? Y_MAX : start_y;
    x1 = (end_x > X_MAX) ? X_MAX : end_x;
    y1 = (end_y > Y_MAX) ? Y_MAX : end_y;
    dx_abs = (x1 >= x0) ? x1 - x0 : x0 - x1;
    dy_abs = (y1 >= y0) ? y1 - y0 : y0 - y1;

    ndy_ext = {{(ERR_W - XW){neg_delta_y[XW-1]}}, neg_delta_y};
    dx_ext  = {{(ERR_W - XW){1'b0}}, delta_x};
    e2      = {err, 1'b0};
    adv_x   = $signed(e2) >= $signed({ndy_ext[ERR_W-1], ndy_ext});
    adv_y   = $signed(e2) <= $signed({1'b0, dx_ext});

    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    tgt_x_next       = tgt_x;
    tgt_y_next       = tgt_y;
    delta_x_next     = delta_x;
    neg_delta_y_next = neg_delta_y;
    x_neg_next       = x_neg;
    y_neg_next       = y_neg;
    err_next         = err;
    color_next       = color;
    busy_next        = busy;
    res_fire         = 1'b0;
    last             = 1'b0;

    if (in_fire) begin
      if (cmd_t'(command) == CMD_START) begin
        cur_x_next       = x0;
        cur_y_next       = y0;
        tgt_x_next       = x1;
        tgt_y_next       = y1;
        color_next       = pen_color;
        x_neg_next       = !(x0 < x1);
        y_neg_next       = !(y0 < y1);
        delta_x_next     = dx_abs;
        neg_delta_y_next = XW'(0) - {1'b0, dy_abs};
        err_next         = {{(ERR_W - XW){1'b0}}, dx_abs}
                         - {{(ERR_W - YW){1'b0}}, dy_abs};
        last             = (x0 == x1) && (y0 == y1);
        busy_next        = !last;
        res_fire         = 1'b1;
      end else if (busy) begin
        if (adv_x) begin
          cur_x_next = x_neg ? cur_x - XW'(1) : cur_x + XW'(1);
        end
        if (adv_y) begin
          cur_y_next = y_neg ? cur_y - YW'(1) : cur_y + YW'(1);
        end
        err_next  = err + (adv_x ? ndy_ext : '0) + (adv_y ? dx_ext : '0);
        last      = (cur_x_next == tgt_x) && (cur_y_next == tgt_y);
        busy_next = !last;
        res_fire  = 1'b1;
      end
    end

    res.x     = cur_x_next;
    res.y     = cur_y_next;
    res.addr  = AW'(cur_x_next[XW-1:1]) + AW'(AW'(cur_y_next) * ROW_BYTES);
    res.upper = cur_x_next[0];
    res.color = color_next;
    res.last  = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      tgt_x       <= '0;
      tgt_y       <= '0;
      delta_x     <= '0;
      neg_delta_y <= '0;
      x_neg       <= 1'b0;
      y_neg       <= 1'b0;
      err         <= '0;
      color       <= '0;
      busy        <= 1'b0;
    end else begin
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      tgt_x       <= tgt_x_next;
      tgt_y       <= tgt_y_next;
      delta_x     <= delta_x_next;
      neg_delta_y <= neg_delta_y_next;
      x_neg       <= x_neg_next;
      y_neg       <= y_neg_next;
      err         <= err_next;
      color       <= color_next;
      busy        <= busy_next;
    end
  end

  // output register plus skid, oldest pixel always in out_pix
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (res_fire) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (res_fire) begin
        skid_pix <= res;
      end
    end else if (skid_valid) begin
      out_pix <= skid_pix;
    end else if (res_fire) begin
      out_pix <= res;
    end
  end

  assign pixel_x      = out_pix.x;
  assign pixel_y      = out_pix.y;
  assign byte_address = out_pix.addr;
  assign upper_nibble = out_pix.upper;
  assign pixel_color  = out_pix.color;
  assign last_pixel   = out_pix.last;

  `ASSERT_IMPL(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `ASSERT_NEXT(a_last_goes_idle, clk, rst, res_fire && res.last, !busy)
  `ASSERT_NEXT(a_more_stays_busy, clk, rst, res_fire && !res.last, busy)
  `ASSERT_NEXT(a_idle_advance_quiet, clk, rst,
               in_fire && cmd_t'(command) == CMD_ADVANCE && !busy, !busy)

endmodule

[verif/line_rasterizer_top_test.sv]
// ---------------------------------------------------------------------------
// line_rasterizer_top_test
// self-checking bench for the line engine: a shadow of the bresenham state is
// stepped on every accepted item and each pixel on out is checked in order
// ---------------------------------------------------------------------------
module line_rasterizer_top_test
  import lr_pkg::*;
();

  class pixel_scoreboard;
    pixel_t        pending_pixels[$];
    logic [XW-1:0] pos_x;
    logic [XW-1:0] goal_x;
    logic [YW-1:0] pos_y;
    logic [YW-1:0] goal_y;
    int            run_x;
    int            fall_y;
    int            err;
    bit            x_back;
    bit            y_back;
    logic [CW-1:0] colour;
    bit            drawing;
    int            pixels_due;
    int            fail_count;

    function new();
      pos_x      = '0;
      goal_x     = '0;
      pos_y      = '0;
      goal_y     = '0;
      run_x      = 0;
      fall_y     = 0;
      err        = 0;
      x_back     = 1'b0;
      y_back     = 1'b0;
      colour     = '0;
      drawing    = 1'b0;
      pixels_due = 0;
      fail_count = 0;
    endfunction

    function void push_pixel(bit last);
      pixel_t p;
      p.x     = pos_x;
      p.y     = pos_y;
      // two pixels share a byte, rows are half the screen width in bytes
      p.addr  = AW'(int'(pos_x) / 2 + int'(pos_y) * (SCREEN_WIDTH / 2));
      p.upper = pos_x[0];
      p.color = colour;
      p.last  = last;
      pending_pixels.push_back(p);
      pixels_due++;
    endfunction

    function void note_item(cmd_t cmd, logic [XW-1:0] sx, logic [YW-1:0] sy,
                            logic [XW-1:0] ex, logic [YW-1:0] ey, logic [CW-1:0] pen);
      int e2;
      bit last;
      if (cmd == CMD_START) begin
        pos_x   = (sx > X_MAX) ? X_MAX : sx;
        pos_y   = (sy > Y_MAX) ? Y_MAX : sy;
        goal_x  = (ex > X_MAX) ? X_MAX : ex;
        goal_y  = (ey > Y_MAX) ? Y_MAX : ey;
        colour  = pen;
        x_back  = !(pos_x < goal_x);
        y_back  = !(pos_y < goal_y);
        run_x   = x_back ? int'(pos_x) - int'(goal_x) : int'(goal_x) - int'(pos_x);
        fall_y  = y_back ? int'(goal_y) - int'(pos_y) : int'(pos_y) - int'(goal_y);
        err     = run_x + fall_y;
        last    = (pos_x == goal_x) && (pos_y == goal_y);
        drawing = !last;
        push_pixel(last);
      end else if (drawing) begin
        // both tests use the error from before this step
        e2 = 2 * err;
        if (e2 >= fall_y) begin
          err   += fall_y;
          pos_x = x_back ? pos_x - 1'b1 : pos_x + 1'b1;
        end
        if (e2 <= run_x) begin
          err   += run_x;
          pos_y = y_back ? pos_y - 1'b1 : pos_y + 1'b1;
        end
        last = (pos_x == goal_x) && (pos_y == goal_y);
        if (last) begin
          drawing = 1'b0;
        end
        push_pixel(last);
      end
    endfunction

    function void compare_field(string name, logic [AW-1:0] want, logic [AW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        fail_count++;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: pixel (%0d,%0d) expected none, got one", $time, got.x, got.y);
        fail_count++;
        return;
      end
      want = pending_pixels.pop_front();
      compare_field("pixel_x", want.x, got.x);
      compare_field("pixel_y", want.y, got.y);
      compare_field("byte_address", want.addr, got.addr);
      compare_field("upper_nibble", want.upper, got.upper);
      compare_field("pixel_color", want.color, got.color);
      compare_field("last_pixel", want.last, got.last);
    endfunction
  endclass

  localparam int IDLE_LIMIT   = 1000;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 8;

  logic          clk          = 1'b0;
  logic          rst          = 1'b1;
  logic          in_valid     = 1'b0;
  logic          in_ready;
  logic          command      = CMD_ADVANCE;
  logic [XW-1:0] start_x      = '0;
  logic [YW-1:0] start_y      = '0;
  logic [XW-1:0] end_x        = '0;
  logic [YW-1:0] end_y        = '0;
  logic [CW-1:0] pen_color    = '0;
  logic          out_valid;
  logic          out_ready    = 1'b0;
  logic [XW-1:0] pixel_x;
  logic [YW-1:0] pixel_y;
  logic [AW-1:0] byte_address;
  logic          upper_nibble;
  logic [CW-1:0] pixel_color;
  logic          last_pixel;

  int              send_gap_pct   = 0;
  int              take_gap_pct   = 0;
  bit              hold_out       = 1'b0;
  int              stalled_cycles = 0;
  pixel_scoreboard sb;

  line_rasterizer_top dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end
      out_ready <= ($urandom_range(0, 99) >= take_gap_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_pixel({pixel_x, pixel_y, byte_address, upper_nibble, pixel_color,
                      last_pixel});
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  task automatic send_item(cmd_t cmd, int sx, int sy, int ex, int ey, int pen);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    start_x   <= XW'(sx);
    start_y   <= YW'(sy);
    end_x     <= XW'(ex);
    end_y     <= YW'(ey);
    pen_color <= CW'(pen);
    do @(posedge clk); while (!in_ready);
    sb.note_item(cmd, XW'(sx), YW'(sy), XW'(ex), YW'(ey), CW'(pen));
  endtask

  // the endpoint fields are don't-care on advance, so they carry noise
  task automatic send_advance();
    send_item(CMD_ADVANCE, $urandom_range(0, 511), $urandom_range(0, 255),
              $urandom_range(0, 511), $urandom_range(0, 255), $urandom_range(0, 15));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_pixels.size() != 0);
  endtask

  function automatic int near(int v, int top);
    int w;
    w = v + int'($urandom_range(0, 24)) - 12;
    return (w < 0) ? 0 : ((w > top) ? top : w);
  endfunction

  task automatic random_line();
    int pick;
    int x0;
    int y0;
    int x1;
    int y1;
    int cap;
    int steps;
    pick = $urandom_range(0, 99);
    cap  = 1000;
    if (pick < 10) begin
      // short lines that may sit partly off screen
      x0 = $urandom_range(0, 511);
      y0 = $urandom_range(0, 255);
      x1 = near(x0, 511);
      y1 = near(y0, 255);
    end else if (pick < 14) begin
      // long spans, cut short to keep the run brief
      x0  = $urandom_range(0, SCREEN_WIDTH - 1);
      y0  = $urandom_range(0, SCREEN_HEIGHT - 1);
      x1  = $urandom_range(0, SCREEN_WIDTH - 1);
      y1  = $urandom_range(0, SCREEN_HEIGHT - 1);
      cap = $urandom_range(0, 20);
    end else begin
      x0 = $urandom_range(0, SCREEN_WIDTH - 1);
      y0 = $urandom_range(0, SCREEN_HEIGHT - 1);
      x1 = near(x0, SCREEN_WIDTH - 1);
      y1 = near(y0, SCREEN_HEIGHT - 1);
    end
    if ($urandom_range(0, 19) == 0) begin
      x1 = x0;
      y1 = y0;
    end
    // now and then a new start lands on a running line
    if ($urandom_range(0, 4) == 0) begin
      cap = $urandom_range(0, 6);
    end
    send_item(CMD_START, x0, y0, x1, y1, $urandom_range(0, 15));
    steps = 0;
    while (sb.drawing && steps < cap) begin
      send_advance();
      steps++;
    end
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 3)) send_advance();
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_advance();
    send_item(CMD_START, 0, 0, 0, 0, 0);
    send_item(CMD_START, 511, 255, 511, 255, 15);
    send_item(CMD_START, 319, 0, 316, 3, 5);
    repeat (3) send_advance();
    send_item(CMD_START, 10, 20, 10, 17, 10);
    repeat (3) send_advance();
    send_item(CMD_START, 5, 5, 9, 6, 3);
    repeat (2) send_advance();
    send_item(CMD_START, 0, 239, 2, 239, 12);
    repeat (3) send_advance();
    send_item(CMD_START, 318, 238, 400, 250, 9);
    send_advance();
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct = (ph == 0) ? 11 : ((ph == 1) ? 79 : 0);
      take_gap_pct = (ph == 0) ? 79 : ((ph == 1) ? 11 : 0);
      if (ph == 2) begin
        // out held back while items keep coming, so the skid fills up
        hold_out = 1'b1;
        send_item(CMD_START, 40, 30, 139, 90, 6);
        while (sb.drawing) begin
          send_advance();
        end
      end
      while (sb.pixels_due < 280 + 270 * ph) begin
        random_line();
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
